>>> rtl/core/bmhq_pkg.sv
// Shared types, sizes and index helpers for the binary min-heap queue.
// No dependencies; imported by the queue unit and the level cell.
package bmhq_pkg;

  localparam int unsigned CAPACITY = 64;
  // heap levels, also the width of the entry count
  localparam int unsigned LEVELS   = $clog2(CAPACITY + 1);
  localparam int unsigned CNT_W    = LEVELS;
  localparam int unsigned LVL_W    = $clog2(LEVELS);
  // position of an entry within its level
  localparam int unsigned POS_W    = LEVELS - 1;
  // a row holds a sibling pair
  localparam int unsigned ROW_W    = (LEVELS > 2) ? LEVELS - 2 : 1;
  localparam int unsigned ROWS     = 1 << ROW_W;
  localparam int unsigned PRIO_W   = 32;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned ENT_W    = PRIO_W + VAL_W;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [LVL_W-1:0] lvl_t;
  typedef logic [POS_W-1:0] pos_t;
  typedef logic [ROW_W-1:0] row_addr_t;

  typedef struct packed {
    logic                     mode;
    logic signed [PRIO_W-1:0] priority_req;
    logic        [VAL_W-1:0]  value;
  } bmhq_in_t;

  typedef struct packed {
    logic        [VAL_W-1:0]  removed_value;
    logic        [VAL_W-1:0]  head_value;
    logic signed [PRIO_W-1:0] head_priority;
    logic                     is_empty;
    logic                     op_error;
  } bmhq_out_t;

  typedef struct packed {
    logic signed [PRIO_W-1:0] prio;
    logic        [VAL_W-1:0]  val;
  } entry_t;

  // sibling pair: even slot is the left child
  typedef struct packed {
    entry_t odd;
    entry_t even;
  } row_t;

  // entry travelling along the chain, with its position in the target level
  typedef struct packed {
    logic   vld;
    entry_t ent;
    pos_t   pos;
  } tok_t;

  typedef struct packed {
    logic      vld;
    row_addr_t row;
  } rd_req_t;

  typedef struct packed {
    logic   done;
    logic   wr;
    entry_t ent;
  } cell_stat_t;

  function automatic row_addr_t row_of(input pos_t p);
    logic [POS_W:0] t;
    t = {1'b0, p};
    return t[ROW_W:1];
  endfunction

  // row of the parent of p, one level up
  function automatic row_addr_t prow_of(input pos_t p);
    logic [POS_W+1:0] t;
    t = {2'b00, p};
    return t[ROW_W+1:2];
  endfunction

  function automatic logic pslot_of(input pos_t p);
    logic [POS_W:0] t;
    t = {1'b0, p};
    return t[1];
  endfunction

  function automatic lvl_t lvl_of(input cnt_t g);
    cnt_t n;
    lvl_t l;
    n = g + 1'b1;
    l = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if (n[i]) l = LVL_W'(i);
    end
    return l;
  endfunction

  function automatic pos_t pos_of(input cnt_t g);
    cnt_t n;
    cnt_t m;
    n = g + 1'b1;
    m = n & ~(CNT_W'(1) << lvl_of(g));
    return POS_W'(m);
  endfunction

endpackage

>>> rtl/core/binary_min_heap_queue_unit.sv
// Binary min-heap priority queue: transaction control and the chain of level cells.
// Depends on bmhq_pkg, bmhq_cell and bmhq_ram.
//
// Usage: drive req_i and raise start; the request transaction is taken on the
// edge where start is high and busy is low. mode selects insert or remove-first.
// Every request yields exactly one result on res_o, marked by res_valid_o for a
// single cycle; the receiver cannot stall, so it must sample on that cycle.
// The heap is held one level per cell, sibling pairs in each row of the cell's
// RAM. An entry moves one level per step: a row read, then a compare and write.
// From accept, an insert sifts its entry up from the first free slot until it
// reaches the root or a compare stops it; a remove loads the last entry into the
// root and sifts it down until it reaches a leaf or a compare stops it. Removing
// the only entry and any rejected request skip the sift and go straight to the
// result. One request is in flight at a time; busy drops on the cycle the result
// is shown, so the next request may be taken then. Each cell's RAM is sized for
// the widest level.
// Reset empties the queue at once (count cleared); no clearing pass is needed.
// Results: removed payload, new head payload and priority (zero when empty), an
// empty flag and an error flag for insert-when-full or remove-when-empty.
module binary_min_heap_queue_unit import bmhq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  bmhq_in_t  req_i,
  output logic      res_valid_o,
  output bmhq_out_t res_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_SIFT = 4'b0100,
    ST_RESP = 4'b1000
  } ctl_st_e;

  ctl_st_e   st_q, st_d;
  cnt_t      count_q;
  entry_t    head_q;
  logic [VAL_W-1:0] removed_q;
  logic      err_q;
  lvl_t      lvl_q;
  logic      slot_q;
  logic      res_valid_q;
  bmhq_out_t res_q;

  logic      accept;
  logic      is_ins;
  logic      full;
  logic      empty;
  logic      ins_go;
  logic      rem_go;
  cnt_t      last_idx;
  pos_t      last_pos;
  lvl_t      ins_lvl;
  entry_t    ins_ent;
  entry_t    last_ent;

  tok_t       dn_tok  [LEVELS+1];
  tok_t       up_out  [LEVELS];
  tok_t       up_in   [LEVELS];
  rd_req_t    ch_req  [LEVELS];
  rd_req_t    par_req [LEVELS];
  rd_req_t    rq_above[LEVELS];
  rd_req_t    rq_below[LEVELS];
  rd_req_t    rq_ctl  [LEVELS];
  row_t       rd_data [LEVELS];
  row_t       ch_data [LEVELS];
  row_t       par_data[LEVELS];
  cell_stat_t stat    [LEVELS];
  logic [LEVELS-1:0] done_v;
  logic [LEVELS-1:0] wr_v;

  assign busy     = (st_q != ST_IDLE);
  assign accept   = start && !busy;
  assign is_ins   = (req_i.mode == MODE_INSERT);
  assign full     = (count_q == CNT_W'(CAPACITY));
  assign empty    = (count_q == '0);
  assign ins_go   = accept && is_ins && !full;
  assign rem_go   = accept && !is_ins && !empty;
  assign last_idx = count_q - CNT_W'(1);
  assign last_pos = pos_of(last_idx);
  assign ins_lvl  = lvl_of(count_q);
  assign ins_ent  = '{prio: req_i.priority_req, val: req_i.value};
  assign last_ent = slot_q ? rd_data[lvl_q].odd : rd_data[lvl_q].even;

  // the moved last entry enters at the root
  assign dn_tok[0] = '{vld: (st_q == ST_LOAD), ent: last_ent, pos: '0};

  for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
    tok_t inj;

    assign inj       = '{vld: ins_go && (ins_lvl == LVL_W'(l)), ent: ins_ent,
                         pos: pos_of(count_q)};
    assign rq_ctl[l] = '{vld: rem_go && (lvl_of(last_idx) == LVL_W'(l)),
                         row: row_of(last_pos)};
    assign done_v[l] = stat[l].done;
    assign wr_v[l]   = stat[l].wr;

    if (l == 0) begin : g_top
      assign rq_above[l] = '0;
      assign par_data[l] = '0;
    end else begin : g_mid
      assign rq_above[l] = ch_req[l-1];
      assign par_data[l] = rd_data[l-1];
    end

    if (l == LEVELS - 1) begin : g_last
      assign rq_below[l] = '0;
      assign ch_data[l]  = '0;
      assign up_in[l]    = inj;
    end else begin : g_inner
      assign rq_below[l] = par_req[l+1];
      assign ch_data[l]  = rd_data[l+1];
      assign up_in[l]    = up_out[l+1].vld ? up_out[l+1] : inj;
    end

    bmhq_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .level_i    (LVL_W'(l)),
      .cnt_i      (count_q),
      .dn_tok_i   (dn_tok[l]),
      .up_tok_i   (up_in[l]),
      .ch_data_i  (ch_data[l]),
      .par_data_i (par_data[l]),
      .rq_above_i (rq_above[l]),
      .rq_below_i (rq_below[l]),
      .rq_ctl_i   (rq_ctl[l]),
      .dn_tok_o   (dn_tok[l+1]),
      .up_tok_o   (up_out[l]),
      .ch_req_o   (ch_req[l]),
      .par_req_o  (par_req[l]),
      .rd_data_o  (rd_data[l]),
      .stat_o     (stat[l])
    );
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (accept) begin
          if (is_ins) begin
            st_d = full ? ST_RESP : ST_SIFT;
          end else if (empty || (count_q == CNT_W'(1))) begin
            st_d = ST_RESP;
          end else begin
            st_d = ST_LOAD;
          end
        end
      end
      ST_LOAD: st_d = ST_SIFT;
      ST_SIFT: begin
        if (done_v != '0) st_d = ST_RESP;
      end
      ST_RESP: st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      res_valid_q <= (st_q == ST_RESP);
      if (ins_go) begin
        count_q <= count_q + CNT_W'(1);
      end else if (rem_go) begin
        count_q <= last_idx;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      removed_q <= rem_go ? head_q.val : '0;
      err_q     <= !(ins_go || rem_go);
      lvl_q     <= lvl_of(last_idx);
      slot_q    <= last_pos[0];
    end
    // mirror of the root slot
    if (stat[0].wr) begin
      head_q <= stat[0].ent;
    end
    if (st_q == ST_RESP) begin
      res_q.removed_value <= removed_q;
      res_q.head_value    <= empty ? '0 : head_q.val;
      res_q.head_priority <= empty ? '0 : head_q.prio;
      res_q.is_empty      <= empty;
      res_q.op_error      <= err_q;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(done_v))
    else $error("more than one level finished a sift in the same cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(wr_v))
    else $error("more than one level written in the same cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !dn_tok[LEVELS].vld && !up_out[0].vld && !ch_req[LEVELS-1].vld && !par_req[0].vld)
    else $error("sift ran off an end of the level chain");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(st_q == ST_RESP))
    else $error("result strobe without a finished transaction");

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

endmodule

>>> rtl/core/bmhq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module bmhq_ram #(
  parameter  int unsigned WIDTH = 64,
  parameter  int unsigned DEPTH = 32,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/bmhq_cell.sv
// One heap level: pair-row storage plus the sift step for an entry at this level.
// Depends on bmhq_pkg and bmhq_ram.
module bmhq_cell import bmhq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  lvl_t       level_i,
  input  cnt_t       cnt_i,
  input  tok_t       dn_tok_i,
  input  tok_t       up_tok_i,
  input  row_t       ch_data_i,
  input  row_t       par_data_i,
  input  rd_req_t    rq_above_i,
  input  rd_req_t    rq_below_i,
  input  rd_req_t    rq_ctl_i,
  output tok_t       dn_tok_o,
  output tok_t       up_tok_o,
  output rd_req_t    ch_req_o,
  output rd_req_t    par_req_o,
  output row_t       rd_data_o,
  output cell_stat_t stat_o
);

  typedef enum logic [4:0] {
    CS_IDLE   = 5'b00001,
    CS_DN_CHK = 5'b00010,
    CS_DN_CMP = 5'b00100,
    CS_UP_CHK = 5'b01000,
    CS_UP_CMP = 5'b10000
  } cell_st_e;

  cell_st_e st_q, st_d;
  entry_t   ent_q;
  pos_t     pos_q;

  cnt_t             base;
  cnt_t             gidx;
  logic [CNT_W:0]   left_idx;
  logic [CNT_W:0]   right_idx;
  logic [CNT_W:0]   cnt_ext;
  logic             no_child;
  logic             right_ok;
  logic             pick_r;
  entry_t           pick;
  entry_t           parent;
  logic             wr;
  entry_t           wr_ent;
  logic             done;
  row_addr_t        raddr;
  entry_t           rd_even;
  entry_t           rd_odd;

  // global index of the held entry and of its children
  assign base      = (CNT_W'(1) << level_i) - CNT_W'(1);
  assign gidx      = base + CNT_W'(pos_q);
  assign left_idx  = {gidx, 1'b1};
  assign right_idx = left_idx + 1'b1;
  assign cnt_ext   = {1'b0, cnt_i};
  assign no_child  = left_idx >= cnt_ext;
  assign right_ok  = right_idx < cnt_ext;

  assign pick_r = right_ok && (ch_data_i.odd.prio < ch_data_i.even.prio);
  assign pick   = pick_r ? ch_data_i.odd : ch_data_i.even;
  assign parent = pslot_of(pos_q) ? par_data_i.odd : par_data_i.even;

  always_comb begin
    st_d      = st_q;
    wr        = 1'b0;
    wr_ent    = ent_q;
    done      = 1'b0;
    dn_tok_o  = '0;
    up_tok_o  = '0;
    ch_req_o  = '0;
    par_req_o = '0;
    case (st_q)
      CS_IDLE: begin
        if (dn_tok_i.vld) begin
          st_d = CS_DN_CHK;
        end else if (up_tok_i.vld) begin
          st_d = CS_UP_CHK;
        end
      end
      CS_DN_CHK: begin
        if (no_child) begin
          wr   = 1'b1;
          done = 1'b1;
          st_d = CS_IDLE;
        end else begin
          ch_req_o.vld = 1'b1;
          ch_req_o.row = ROW_W'(pos_q);
          st_d         = CS_DN_CMP;
        end
      end
      CS_DN_CMP: begin
        wr   = 1'b1;
        st_d = CS_IDLE;
        if (ent_q.prio > pick.prio) begin
          wr_ent       = pick;
          dn_tok_o.vld = 1'b1;
          dn_tok_o.ent = ent_q;
          dn_tok_o.pos = POS_W'({pos_q, pick_r});
        end else begin
          done = 1'b1;
        end
      end
      CS_UP_CHK: begin
        if (level_i == '0) begin
          wr   = 1'b1;
          done = 1'b1;
          st_d = CS_IDLE;
        end else begin
          par_req_o.vld = 1'b1;
          par_req_o.row = prow_of(pos_q);
          st_d          = CS_UP_CMP;
        end
      end
      CS_UP_CMP: begin
        wr   = 1'b1;
        st_d = CS_IDLE;
        if (parent.prio > ent_q.prio) begin
          wr_ent       = parent;
          up_tok_o.vld = 1'b1;
          up_tok_o.ent = ent_q;
          up_tok_o.pos = POS_W'(pos_q >> 1);
        end else begin
          done = 1'b1;
        end
      end
      default: st_d = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= CS_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == CS_IDLE) begin
      if (dn_tok_i.vld) begin
        ent_q <= dn_tok_i.ent;
        pos_q <= dn_tok_i.pos;
      end else if (up_tok_i.vld) begin
        ent_q <= up_tok_i.ent;
        pos_q <= up_tok_i.pos;
      end
    end
  end

  // at most one requester is active at a time
  always_comb begin
    if (rq_above_i.vld) begin
      raddr = rq_above_i.row;
    end else if (rq_below_i.vld) begin
      raddr = rq_below_i.row;
    end else begin
      raddr = rq_ctl_i.row;
    end
  end

  bmhq_ram #(.WIDTH(ENT_W), .DEPTH(ROWS)) u_ram_even (
    .clk_i   (clk_i),
    .we_i    (wr && !pos_q[0]),
    .waddr_i (row_of(pos_q)),
    .wdata_i (wr_ent),
    .raddr_i (raddr),
    .rdata_o (rd_even)
  );

  bmhq_ram #(.WIDTH(ENT_W), .DEPTH(ROWS)) u_ram_odd (
    .clk_i   (clk_i),
    .we_i    (wr && pos_q[0]),
    .waddr_i (row_of(pos_q)),
    .wdata_i (wr_ent),
    .raddr_i (raddr),
    .rdata_o (rd_odd)
  );

  assign rd_data_o.even = rd_even;
  assign rd_data_o.odd  = rd_odd;

  assign stat_o.done = done;
  assign stat_o.wr   = wr;
  assign stat_o.ent  = wr_ent;

endmodule
